@@ rtl/nstrg_pkg.sv @@
`timescale 1ns / 1ps

package nstrg_pkg;

  // Table size default and register map
  localparam int unsigned SUBSCRIBER_SLOTS_DEF = 4;
  localparam int unsigned PADDR_W              = 3;
  localparam logic [PADDR_W-3:0] REG_NOTIFY_INTERVAL = '0;
  localparam logic [31:0] INTERVAL_RESET       = 32'd1000;

  // Descriptor and payload constants
  localparam logic [15:0] CCCD_NOTIFY_EN = 16'h0001;
  localparam logic [7:0]  RATE_MAX       = 8'd255;
  localparam logic [7:0]  FLAGS_UINT8    = 8'h00;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_SUBSCRIBE  = 3'd0,
    CMD_DISCONNECT = 3'd1,
    CMD_UPDATE     = 3'd2,
    CMD_START      = 3'd3,
    CMD_STOP       = 3'd4
  } cmd_e;

  // Table operation carried along the cell chain
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_DROP = 1'b1
  } op_e;

  typedef struct packed {
    logic        valid;
    op_e         op;
    logic [15:0] handle;
    logic        found;      // handle already active in an earlier cell
    logic        free_seen;  // an earlier cell was free
    logic        any;        // some earlier cell is active after the op
  } tok_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] handle;
  } commit_t;

endpackage

@@ rtl/notify_subscriber_table_rate_gate_top.sv @@
`timescale 1ns / 1ps
// Order: a subscribe or disconnect while started walks through the chain of table cells, then
// through ST_EMIT into the output register; every other command goes to ST_EMIT directly.
// The input stalls while an item is in progress, until it has left ST_EMIT; a table write
// walks its operation through the chain of table cells, one cell per cycle.
// Reset: asynchronous, active low; clears the table, the started flag, the time stamp and the
// output register, and loads the notify interval with 1000 ms.

module notify_subscriber_table_rate_gate_top import nstrg_pkg::*; #(
  parameter int unsigned SUBSCRIBER_SLOTS = SUBSCRIBER_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [15:0]        connection_handle_i,
  input  logic [15:0]        subscription_value_i,
  input  logic [31:0]        now_ms_i,
  input  logic               rate_valid_i,
  input  logic [15:0]        rate_bpm_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               notify_o,
  output logic [7:0]         payload_flags_o,
  output logic [7:0]         payload_rate_o,
  output logic               has_subscribers_o,
  output logic               is_initialized_o,
  output logic [31:0]        last_notify_time_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] interval_q;
  logic        started_q, started_d;
  logic        any_q, any_d;
  logic [31:0] stamp_q, stamp_d;
  logic        notify_q, notify_d;
  logic [7:0]  rate_q, rate_d;

  logic        out_valid_q;
  logic        out_notify_q;
  logic [7:0]  out_rate_q;
  logic        out_any_q;
  logic        out_started_q;
  logic [31:0] out_stamp_q;

  logic        in_xfer;
  logic        cfg_wr;
  logic        clear;
  logic [31:0] elapsed;
  logic        rate_ok;
  logic        out_free;
  tok_t        tok [SUBSCRIBER_SLOTS+1];
  commit_t     commit;

  // Configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_NOTIFY_INTERVAL);
  assign prdata = (paddr[PADDR_W-1:2] == REG_NOTIFY_INTERVAL) ? interval_q : '0;

  // Handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign elapsed = now_ms_i - stamp_q;
  assign rate_ok = rate_valid_i && (rate_bpm_i != '0) && (rate_bpm_i[15:8] == '0);

  // Launch table operations into the chain
  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = in_xfer && started_q &&
                       ((command_i == CMD_SUBSCRIBE) || (command_i == CMD_DISCONNECT));
    tok[0].op        = ((command_i == CMD_SUBSCRIBE) &&
                        ((subscription_value_i & CCCD_NOTIFY_EN) != '0)) ? OP_ADD : OP_DROP;
    tok[0].handle    = connection_handle_i;
  end

  // Insert into the first free cell when the walk found no copy
  assign commit.valid  = tok[SUBSCRIBER_SLOTS].valid && (tok[SUBSCRIBER_SLOTS].op == OP_ADD) &&
                         !tok[SUBSCRIBER_SLOTS].found && tok[SUBSCRIBER_SLOTS].free_seen;
  assign commit.handle = tok[SUBSCRIBER_SLOTS].handle;

  assign clear = in_xfer && (((command_i == CMD_START) && !started_q) ||
                             ((command_i == CMD_STOP) && started_q));

  for (genvar g = 0; g < SUBSCRIBER_SLOTS; g++) begin : g_cell
    nstrg_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (clear),
      .commit_i (commit),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  // Sequence one item and decode its command
  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    any_d     = any_q;
    stamp_d   = stamp_q;
    notify_d  = notify_q;
    rate_d    = rate_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          notify_d = 1'b0;
          rate_d   = '0;
          state_d  = ST_EMIT;
          case (command_i)
            CMD_SUBSCRIBE, CMD_DISCONNECT: begin
              if (started_q) state_d = ST_WALK;
            end
            CMD_UPDATE: begin
              if (started_q && any_q && (elapsed >= interval_q)) begin
                stamp_d = now_ms_i;
                if (rate_ok) begin
                  notify_d = 1'b1;
                  rate_d   = rate_bpm_i[7:0] & RATE_MAX;
                end
              end
            end
            CMD_START: begin
              if (!started_q) begin
                started_d = 1'b1;
                any_d     = 1'b0;
                stamp_d   = '0;
              end
            end
            CMD_STOP: begin
              if (started_q) begin
                started_d = 1'b0;
                any_d     = 1'b0;
                stamp_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (tok[SUBSCRIBER_SLOTS].valid) begin
          any_d   = tok[SUBSCRIBER_SLOTS].any || commit.valid;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      interval_q    <= INTERVAL_RESET;
      started_q     <= 1'b0;
      any_q         <= 1'b0;
      stamp_q       <= '0;
      notify_q      <= 1'b0;
      rate_q        <= '0;
      out_valid_q   <= 1'b0;
      out_notify_q  <= 1'b0;
      out_rate_q    <= '0;
      out_any_q     <= 1'b0;
      out_started_q <= 1'b0;
      out_stamp_q   <= '0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      any_q     <= any_d;
      stamp_q   <= stamp_d;
      notify_q  <= notify_d;
      rate_q    <= rate_d;
      if (cfg_wr) interval_q <= pwdata;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q   <= 1'b1;
        out_notify_q  <= notify_q;
        out_rate_q    <= rate_q;
        out_any_q     <= any_q;
        out_started_q <= started_q;
        out_stamp_q   <= stamp_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign notify_o           = out_notify_q;
  assign payload_flags_o    = FLAGS_UINT8;
  assign payload_rate_o     = out_rate_q;
  assign has_subscribers_o  = out_any_q;
  assign is_initialized_o   = out_started_q;
  assign last_notify_time_o = out_stamp_q;

endmodule

@@ rtl/nstrg_cell.sv @@
`timescale 1ns / 1ps

module nstrg_cell import nstrg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    clear_i,
  input  commit_t commit_i,
  input  tok_t    tok_i,
  output tok_t    tok_o
);

  logic        active_q, active_d;
  logic [15:0] handle_q, handle_d;
  logic        cand_q, cand_d;
  tok_t        tok_q, tok_d;
  logic        hit;

  assign hit = (handle_q == tok_i.handle);

  // Annotate the passing operation with this entry
  always_comb begin
    tok_d = tok_i;
    if (tok_i.op == OP_ADD) begin
      tok_d.found     = tok_i.found | (active_q & hit);
      tok_d.free_seen = tok_i.free_seen | ~active_q;
      tok_d.any       = tok_i.any | active_q;
    end else begin
      tok_d.any       = tok_i.any | (active_q & ~hit);
    end
  end

  // Update the entry: clear, drop on match, mark the first free cell on an add, or take a committed add
  always_comb begin
    active_d = active_q;
    handle_d = handle_q;
    cand_d   = cand_q;
    if (clear_i) begin
      active_d = 1'b0;
      handle_d = '0;
      cand_d   = 1'b0;
    end else if (tok_i.valid && tok_i.op == OP_DROP && hit) begin
      active_d = 1'b0;
      handle_d = '0;
    end else if (tok_i.valid && tok_i.op == OP_ADD) begin
      cand_d = ~active_q & ~tok_i.free_seen;
    end else if (commit_i.valid && cand_q) begin
      active_d = 1'b1;
      handle_d = commit_i.handle;
      cand_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      handle_q <= '0;
      cand_q   <= 1'b0;
      tok_q    <= '0;
    end else begin
      active_q <= active_d;
      handle_q <= handle_d;
      cand_q   <= cand_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/nstrg_checker.sv @@
`timescale 1ns / 1ps

module nstrg_checker import nstrg_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               notify_o,
  input logic [7:0]         payload_flags_o,
  input logic [7:0]         payload_rate_o,
  input logic               has_subscribers_o,
  input logic               is_initialized_o,
  input logic [31:0]        last_notify_time_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(last_notify_time_o) &&
      $stable(notify_o) && $stable(payload_rate_o))
    else $error("stalled result changed");

  // A notification needs a started service with subscribers, a nonzero rate and uint8 flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && notify_o |-> is_initialized_o && has_subscribers_o &&
      (payload_rate_o != '0) && (payload_flags_o == FLAGS_UINT8))
    else $error("notification without service, subscribers or rate");

  // No rate byte without a notification
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !notify_o |-> payload_rate_o == '0)
    else $error("rate byte set without notification");

  // A stopped service has an empty table and no time stamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_initialized_o |-> !has_subscribers_o && (last_notify_time_o == '0))
    else $error("stopped service holds table or stamp");

endmodule

bind notify_subscriber_table_rate_gate_top nstrg_checker u_nstrg_checker (.*);
